// ----- design/msss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_pkg
// Shared types, codes and the digit font for the seven-segment scanner.
// ----------------------------------------------------------------------------
package msss_pkg;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_RAW   = 2'd0,
    KIND_TIME  = 2'd1,
    KIND_TEMP  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic CFG_SEG_ACTIVE_HIGH = 1'b0;
  localparam logic CFG_DIG_ACTIVE_HIGH = 1'b1;

  // digits filled by a time or temperature write
  localparam int unsigned FMT_DIGITS = 6;

  localparam logic [7:0] POINT_BIT = 8'h80;
  localparam logic [7:0] MINUS_PAT = 8'h40;
  localparam logic [7:0] BLANK_PAT = 8'h00;

  // output target chain
  localparam logic TARGET_DIGIT   = 1'b0;
  localparam logic TARGET_SEGMENT = 1'b1;

  typedef logic [FMT_DIGITS-1:0][7:0] fmt_digits_t;

  // one tick's worth of frame data handed to the output stage
  typedef struct packed {
    logic [7:0]  segs;
    logic [7:0]  enable;
    logic [7:0]  all_off;
    logic [31:0] count;
  } frame_load_t;

  // frame sequencer states
  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_OFF  = 2'd1,
    FR_SEG  = 2'd2,
    FR_EN   = 2'd3
  } frame_state_t;

  // decimal digit to segment pattern, bit0 segment a
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = BLANK_PAT;
    endcase
    return g;
  endfunction

endpackage

// ----- design/msss_format.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_format
// Turns a time or temperature write into six digit patterns.
// ----------------------------------------------------------------------------
module msss_format (
  input  logic                  colon,
  input  logic [6:0]            hours,
  input  logic [6:0]            minutes,
  input  logic [6:0]            seconds,
  input  logic signed [10:0]    temperature,
  input  logic                  is_temp,
  output msss_pkg::fmt_digits_t digits
);
  import msss_pkg::*;

  logic [7:0]  dp;
  logic [3:0]  tens_h, ones_h, tens_m, ones_m, tens_s, ones_s;
  logic        neg;
  logic [10:0] mag;
  logic [17:0] prod10;
  logic [15:0] prod100;
  logic [6:0]  q10;
  logic [3:0]  q100;
  logic [3:0]  t_tenths, t_ones, t_tens;
  fmt_digits_t time_digits, temp_digits;

  // split a value below 128 into tens (mod 10) and ones
  function automatic logic [7:0] split_dec(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(v) * 15'd205;
    q = p[14:11];
    r = v - 7'(q) * 7'd10;
    if (q >= 4'd10) q = q - 4'd10;
    return {q, r[3:0]};
  endfunction

  // time layout
  assign dp = colon ? POINT_BIT : BLANK_PAT;
  assign {tens_h, ones_h} = split_dec(hours);
  assign {tens_m, ones_m} = split_dec(minutes);
  assign {tens_s, ones_s} = split_dec(seconds);

  always_comb begin
    time_digits[0] = glyph(tens_h);
    time_digits[1] = glyph(ones_h) | dp;
    time_digits[2] = glyph(tens_m);
    time_digits[3] = glyph(ones_m) | dp;
    time_digits[4] = glyph(tens_s);
    time_digits[5] = glyph(ones_s);
  end

  // temperature magnitude, minus 1024 stays 1024 in 11 bits
  assign neg = temperature[10];
  assign mag = neg ? (~temperature + 11'd1) : temperature;

  // reciprocal multiplies, exact for magnitudes up to 1024
  assign prod10   = 18'(mag) * 18'd205;
  assign prod100  = 16'(mag) * 16'd41;
  assign q10      = prod10[17:11];
  assign q100     = prod100[15:12];
  assign t_tenths = 4'(mag - 11'(q10) * 11'd10);
  assign t_ones   = 4'(q10 - 7'(q100) * 7'd10);
  assign t_tens   = (q100 >= 4'd10) ? (q100 - 4'd10) : q100;

  always_comb begin
    temp_digits[0] = neg ? MINUS_PAT : BLANK_PAT;
    temp_digits[1] = (q100 != 4'd0) ? glyph(t_tens) : BLANK_PAT;
    temp_digits[2] = glyph(t_ones) | POINT_BIT;
    temp_digits[3] = glyph(t_tenths);
    temp_digits[4] = BLANK_PAT;
    temp_digits[5] = BLANK_PAT;
  end

  assign digits = is_temp ? temp_digits : time_digits;

endmodule

// ----- design/msss_frames.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_frames
// Output register that plays one tick out as three frame beats.
// ----------------------------------------------------------------------------
module msss_frames (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  msss_pkg::frame_load_t load_data,
  output logic                  load_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,   // frame_byte[7:0], elapsed_ticks[39:8]
  output logic                  out_tuser,   // target
  output logic                  out_tlast
);
  import msss_pkg::*;

  frame_state_t state_r, state_nxt;
  frame_load_t  data_r;
  logic         beat_done;
  logic [7:0]   frame_byte;

  assign beat_done  = out_tvalid && out_tready;
  assign load_ready = (state_r == FR_IDLE) || ((state_r == FR_EN) && out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: if (load) state_nxt = FR_OFF;
      FR_OFF:  if (beat_done) state_nxt = FR_SEG;
      FR_SEG:  if (beat_done) state_nxt = FR_EN;
      FR_EN: begin
        if (beat_done) state_nxt = load ? FR_OFF : FR_IDLE;
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      data_r <= load_data;
    end
  end

  // beat outputs
  always_comb begin
    out_tvalid = 1'b1;
    out_tuser  = TARGET_DIGIT;
    out_tlast  = 1'b0;
    frame_byte = data_r.all_off;
    unique case (state_r)
      FR_IDLE: out_tvalid = 1'b0;
      FR_OFF:  frame_byte = data_r.all_off;
      FR_SEG: begin
        out_tuser  = TARGET_SEGMENT;
        frame_byte = data_r.segs;
      end
      FR_EN: begin
        out_tlast  = 1'b1;
        frame_byte = data_r.enable;
      end
      default: out_tvalid = 1'b0;
    endcase
  end

  assign out_tdata = {data_r.count, frame_byte};

  // checks
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load && !load_ready |-> state_r != FR_IDLE)
    else $error("frame load while busy");
  a_seq_seg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FR_OFF && beat_done |=> state_r == FR_SEG)
    else $error("segment beat did not follow all-off beat");
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_OFF || state_r == FR_SEG) |=> $stable(data_r.count))
    else $error("tick count changed mid tick");

endmodule

// ----- design/multiplexed_seven_segment_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner
// Digit pattern store with time/temperature formatting and tick-driven scan.
// ----------------------------------------------------------------------------
// An item is accepted every cycle while no tick waits for the output stage;
// it is held in the input register, where writes update the digit store. A
// refresh tick yields three output beats (all enables off, segment byte,
// one-hot enable, the last with tlast) which the output frame register sends
// one per cycle while out_tready is high; the next tick can load as the last
// beat is taken, and writes between ticks still go at one per cycle. The
// first frame of a tick is presented once it is loaded into the frame register.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner #(
  parameter int unsigned DIGIT_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position, pattern, hours, minutes, seconds,
                                  // colon, temperature
  input  logic [1:0]  in_tuser,   // kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // frame_byte, elapsed_ticks
  output logic        out_tuser,  // target
  output logic        out_tlast
);
  import msss_pkg::*;

  localparam int unsigned IDX_W = $clog2(DIGIT_COUNT);

  logic                        s1_valid_r;
  kind_t                       kind_r;
  logic [47:0]                 data_r;
  logic                        seg_hi_r, dig_hi_r;
  logic [DIGIT_COUNT-1:0][7:0] digits_r;
  logic [IDX_W-1:0]            scan_r, scan_nxt;
  logic [31:0]                 count_r, count_nxt;
  logic                        s1_adv, is_tick, tick_go, frame_ready;
  fmt_digits_t                 fmt;
  frame_load_t                 load_data;
  logic [7:0]                  onehot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_hi_r <= 1'b1;
      dig_hi_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEG_ACTIVE_HIGH: seg_hi_r <= cfg_wdata;
        CFG_DIG_ACTIVE_HIGH: dig_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign is_tick   = (kind_r == KIND_TICK);
  assign s1_adv    = s1_valid_r && (!is_tick || frame_ready);
  assign tick_go   = s1_adv && is_tick;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= kind_t'(in_tuser);
      data_r <= in_tdata;
    end
  end

  // time and temperature formatting
  msss_format u_format (
    .colon       (data_r[32]),
    .hours       (data_r[17:11]),
    .minutes     (data_r[24:18]),
    .seconds     (data_r[31:25]),
    .temperature (data_r[43:33]),
    .is_temp     (kind_r == KIND_TEMP),
    .digits      (fmt)
  );

  // digit pattern store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (kind_r == KIND_RAW && data_r[2:0] == 3'(i)) begin
          digits_r[i] <= data_r[10:3];
        end else if ((kind_r == KIND_TIME || kind_r == KIND_TEMP) && i < FMT_DIGITS) begin
          digits_r[i] <= fmt[i];
        end
      end
    end
  end

  // scan position and tick counter
  assign scan_nxt  = (scan_r == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_r + 1'b1;
  assign count_nxt = count_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      count_r <= '0;
    end else if (tick_go) begin
      scan_r  <= scan_nxt;
      count_r <= count_nxt;
    end
  end

  // frame contents for this tick
  assign onehot = 8'(9'd1 << scan_r);
  always_comb begin
    load_data.segs    = digits_r[scan_r] ^ {8{~seg_hi_r}};
    load_data.enable  = onehot ^ {8{~dig_hi_r}};
    load_data.all_off = {8{~dig_hi_r}};
    load_data.count   = count_nxt;
  end

  msss_frames u_frames (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (tick_go),
    .load_data  (load_data),
    .load_ready (frame_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_r) < DIGIT_COUNT)
    else $error("scan position out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> count_r == $past(count_r) + 32'd1)
    else $error("tick counter did not step");
  a_write_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !is_tick |=> $stable(count_r) && $stable(scan_r))
    else $error("write moved the scan state");

endmodule
